[rtl/intensity_histogram_engine_assert.svh]
// Assertion macros for the intensity histogram engine.
`ifndef INTENSITY_HISTOGRAM_ENGINE_ASSERT_SVH
`define INTENSITY_HISTOGRAM_ENGINE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define IHE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram engine: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define IHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram engine: next-cycle check failed");

`endif

[rtl/ihe_pkg.sv]
// Shared types, codes and defaults for the intensity histogram engine.
`timescale 1ns / 1ps

package ihe_pkg;

    // Fixed field widths
    localparam int COMMAND_W   = 3;
    localparam int INTENSITY_W = 8;
    localparam int BIN_COUNT_W = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Parameter defaults
    localparam int DEF_NUM_BINS    = 256;
    localparam int DEF_COUNT_WIDTH = 24;

    // Register reset value
    localparam logic [INTENSITY_W-1:0] MAX_INTENSITY_RST = 8'd255;

    // Register index, taken from paddr[2]
    localparam logic REG_MAX_INTENSITY = 1'b0;

    // Command codes
    localparam logic [COMMAND_W-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [COMMAND_W-1:0] CMD_ADD      = 3'd1;
    localparam logic [COMMAND_W-1:0] CMD_CUMULATE = 3'd2;
    localparam logic [COMMAND_W-1:0] CMD_READ     = 3'd3;
    localparam logic [COMMAND_W-1:0] CMD_RANGE    = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch the request and set up the address
        logic rd_en;     // read the bin at the current address
        logic ex_en;     // act on the read data
        logic clr_wr;    // write zero at the current address
        logic addr_inc;  // advance the address
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_oor;    // incoming intensity lies above the active range
        logic at_top;    // address is the last active bin
        logic at_last;   // address is the last bin of the store
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

[rtl/ihe_ctrl.sv]
// Controller state machine of the intensity histogram engine.
`timescale 1ns / 1ps

module ihe_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [ihe_pkg::COMMAND_W-1:0]  i_command,
    input  ihe_pkg::t_dp_stat              i_stat,
    output ihe_pkg::t_dp_cmd               o_cmd,
    output logic                           o_in_stall
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EX   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic [ihe_pkg::COMMAND_W-1:0]       r_cmd;
    logic [ihe_pkg::COMMAND_W-1:0]       n_cmd;

    // Hold state and latched command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cmd   <= ihe_pkg::CMD_CLEAR;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    // Sequence the datapath
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.at_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cmd      = i_command;
                    if (i_command == ihe_pkg::CMD_CLEAR) begin
                        n_state = S_CLR;
                    end else if (i_command inside {ihe_pkg::CMD_ADD, ihe_pkg::CMD_READ}) begin
                        n_state = i_stat.in_oor ? S_DONE : S_RD;
                    end else if (i_command inside {ihe_pkg::CMD_CUMULATE,
                                                   ihe_pkg::CMD_RANGE}) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.at_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EX;
            end
            S_EX: begin
                o_cmd.ex_en = 1'b1;
                if ((r_cmd inside {ihe_pkg::CMD_CUMULATE, ihe_pkg::CMD_RANGE})
                        && !i_stat.at_top) begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/ihe_datapath.sv]
// Bin store, accumulators and output register of the histogram engine.
`timescale 1ns / 1ps

module ihe_datapath #(
    parameter int NUM_BINS    = ihe_pkg::DEF_NUM_BINS,
    parameter int COUNT_WIDTH = ihe_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ihe_pkg::t_dp_cmd                 i_cmd,
    output ihe_pkg::t_dp_stat                o_stat,
    input  logic [ihe_pkg::COMMAND_W-1:0]    i_command,
    input  logic [ihe_pkg::INTENSITY_W-1:0]  i_intensity,
    input  logic [ihe_pkg::INTENSITY_W-1:0]  i_max_intensity,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [ihe_pkg::BIN_COUNT_W-1:0]  o_bin_count,
    output logic [ihe_pkg::INTENSITY_W-1:0]  o_lowest_used,
    output logic [ihe_pkg::INTENSITY_W-1:0]  o_highest_used,
    output logic                             o_range_empty,
    output logic                             o_out_of_range,
    output logic                             o_saturated
);

    localparam int AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int IW  = ihe_pkg::INTENSITY_W;
    localparam int CW  = COUNT_WIDTH;
    localparam int BW  = ihe_pkg::BIN_COUNT_W;
    localparam logic [AW-1:0] LAST_BIN  = AW'(NUM_BINS - 1);
    localparam logic [CW-1:0] COUNT_TOP = {CW{1'b1}};

    logic [CW-1:0]          r_mem [NUM_BINS];
    logic [CW-1:0]          r_rd_data;
    logic [AW-1:0]          r_addr;
    logic [ihe_pkg::COMMAND_W-1:0] r_cmd;
    logic [CW-1:0]          r_sum;
    logic                   r_found;
    logic [AW-1:0]          r_low;
    logic [AW-1:0]          r_high;
    logic [CW-1:0]          r_count;
    logic                   r_oor;
    logic                   r_sat;
    logic                   r_out_valid;

    logic [AW+IW-1:0]       max_ext;
    logic [AW+IW-1:0]       last_ext;
    logic [AW+IW-1:0]       in_ext;
    logic [AW-1:0]          top;
    logic [AW-1:0]          in_addr;
    logic                   is_addr_cmd;
    logic [CW:0]            sum_ext;
    logic [CW-1:0]          cum_val;
    logic                   cum_sat;
    logic [CW-1:0]          inc_val;
    logic                   mem_we;
    logic [CW-1:0]          mem_wdata;
    logic [CW+BW-1:0]       count_ext;
    logic [AW+IW-1:0]       low_ext;
    logic [AW+IW-1:0]       high_ext;

    // Clamp the active range to the store
    assign max_ext  = {{AW{1'b0}}, i_max_intensity};
    assign last_ext = {{IW{1'b0}}, LAST_BIN};
    assign top      = (max_ext > last_ext) ? LAST_BIN : max_ext[AW-1:0];

    // Check the incoming intensity against the active range
    assign in_ext      = {{AW{1'b0}}, i_intensity};
    assign in_addr     = in_ext[AW-1:0];
    assign is_addr_cmd = (i_command == ihe_pkg::CMD_ADD) || (i_command == ihe_pkg::CMD_READ);

    // Saturating running sum and saturating increment
    assign sum_ext = {1'b0, r_sum} + {1'b0, r_rd_data};
    assign cum_sat = (sum_ext >= {1'b0, COUNT_TOP});
    assign cum_val = cum_sat ? COUNT_TOP : sum_ext[CW-1:0];
    assign inc_val = (r_rd_data == COUNT_TOP) ? COUNT_TOP : (r_rd_data + CW'(1));

    // Select the store write
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (i_cmd.clr_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.ex_en && (r_cmd == ihe_pkg::CMD_ADD)) begin
            mem_we    = 1'b1;
            mem_wdata = inc_val;
        end else if (i_cmd.ex_en && (r_cmd == ihe_pkg::CMD_CUMULATE)) begin
            mem_we    = 1'b1;
            mem_wdata = cum_val;
        end
    end

    // Bin store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Advance or load the bin address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load) begin
            r_addr <= is_addr_cmd ? in_addr : '0;
        end else if (i_cmd.addr_inc) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    // Latch the request and accumulate its result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_sum   <= '0;
            r_found <= 1'b0;
            r_low   <= '0;
            r_high  <= '0;
            r_count <= '0;
            r_oor   <= is_addr_cmd && (in_ext > {{IW{1'b0}}, top});
            r_sat   <= 1'b0;
        end else if (i_cmd.ex_en) begin
            case (r_cmd)
                ihe_pkg::CMD_ADD: begin
                    r_count <= inc_val;
                    r_sat   <= (inc_val == COUNT_TOP);
                end
                ihe_pkg::CMD_READ: begin
                    r_count <= r_rd_data;
                end
                ihe_pkg::CMD_CUMULATE: begin
                    r_sum <= cum_val;
                    if (cum_sat) begin
                        r_sat <= 1'b1;
                    end
                    if (r_addr == top) begin
                        r_count <= cum_val;
                    end
                end
                ihe_pkg::CMD_RANGE: begin
                    if (r_rd_data != '0) begin
                        if (!r_found) begin
                            r_low <= r_addr;
                        end
                        r_high  <= r_addr;
                        r_found <= 1'b1;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Fit the result fields to the port widths
    assign count_ext = {{BW{1'b0}}, r_count};
    assign low_ext   = {{IW{1'b0}}, r_low};
    assign high_ext  = {{IW{1'b0}}, r_high};

    // Output register: load on request, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_bin_count    <= count_ext[BW-1:0];
            o_lowest_used  <= low_ext[IW-1:0];
            o_highest_used <= high_ext[IW-1:0];
            o_range_empty  <= (r_cmd == ihe_pkg::CMD_RANGE) && !r_found;
            o_out_of_range <= r_oor;
            o_saturated    <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;

    // Report status to the controller
    assign o_stat.in_oor   = in_ext > {{IW{1'b0}}, top};
    assign o_stat.at_top   = (r_addr == top);
    assign o_stat.at_last  = (r_addr == LAST_BIN);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

[rtl/intensity_histogram_engine.sv]
// Top level of the intensity histogram engine: register port and core.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_command, i_intensity
//  output    out        o_out_valid / i_out_stall o_bin_count, o_lowest_used, o_highest_used,
//                                                 o_range_empty, o_out_of_range, o_saturated
//  config    in         psel, penable, pwrite     paddr, pwdata, prdata (max_intensity at 0)
//
// Sequence: add and read visit their bin with a read step and then an act step; an
// out-of-range or unknown command goes straight to the result; cumulate and range
// walk bins 0 up to top, the active limit, with a read and an act step per bin;
// clear writes zero to every bin. After reset a clearing pass zeroes the store
// while o_in_stall stays high. A finished result sits in the output
// register, so the next request is taken while i_out_stall holds the last one.
`timescale 1ns / 1ps
`include "intensity_histogram_engine_assert.svh"

module intensity_histogram_engine #(
    parameter int NUM_BINS    = ihe_pkg::DEF_NUM_BINS,
    parameter int COUNT_WIDTH = ihe_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ihe_pkg::COMMAND_W-1:0]       i_command,
    input  logic [ihe_pkg::INTENSITY_W-1:0]     i_intensity,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ihe_pkg::BIN_COUNT_W-1:0]     o_bin_count,
    output logic [ihe_pkg::INTENSITY_W-1:0]     o_lowest_used,
    output logic [ihe_pkg::INTENSITY_W-1:0]     o_highest_used,
    output logic                                o_range_empty,
    output logic                                o_out_of_range,
    output logic                                o_saturated,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ihe_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ihe_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ihe_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IW = ihe_pkg::INTENSITY_W;

    logic [IW-1:0]       r_max_intensity;
    logic                reg_wr;
    ihe_pkg::t_dp_cmd    dp_cmd;
    ihe_pkg::t_dp_stat   dp_stat;

    // Register port
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_intensity <= ihe_pkg::MAX_INTENSITY_RST;
        end else if (reg_wr && (paddr[2] == ihe_pkg::REG_MAX_INTENSITY)) begin
            r_max_intensity <= pwdata[IW-1:0];
        end
    end

    assign prdata = (paddr[2] == ihe_pkg::REG_MAX_INTENSITY)
                  ? {{(ihe_pkg::APB_DATA_W - IW){1'b0}}, r_max_intensity}
                  : '0;

    // Controller
    ihe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath
    ihe_datapath #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_intensity     (i_intensity),
        .i_max_intensity (r_max_intensity),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_bin_count     (o_bin_count),
        .o_lowest_used   (o_lowest_used),
        .o_highest_used  (o_highest_used),
        .o_range_empty   (o_range_empty),
        .o_out_of_range  (o_out_of_range),
        .o_saturated     (o_saturated)
    );

    // An empty range reports both ends as zero
    `IHE_ASSERT_SAME(a_empty_ends_zero, i_clk, i_rst_n, o_out_valid && o_range_empty, (o_lowest_used == '0) && (o_highest_used == '0))
    // An ignored pixel carries no count and no saturation
    `IHE_ASSERT_SAME(a_oor_no_count, i_clk, i_rst_n, o_out_valid && o_out_of_range, (o_bin_count == '0) && !o_saturated && !o_range_empty)
    // A taken request keeps the input side stalled in the next cycle
    `IHE_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule
